FILE: rtl/core/assert_macros.svh
// Assertion helpers used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, ignored while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

FILE: rtl/core/ctm_pkg.sv
package ctm_pkg;

  // Field and state widths.
  localparam int MIX_W      = 20;
  localparam int TDATA_W    = 24;
  localparam int POS_W      = 25;
  localparam int PHASE_W    = 48;
  localparam int ENV_W      = 25;
  localparam int GAIN_W     = 16;
  localparam int SINE_W     = 16;
  localparam int GE_W       = 18;
  localparam int MIXSUM_W   = 32;
  localparam int TONE_W     = 24;
  localparam int MUL_A_W    = 26;
  localparam int MUL_B_W    = 33;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  // Fixed-point constants.
  localparam int FRAC_SHIFT  = 24;
  localparam int SINE_SHIFT  = 12;
  localparam logic [ENV_W-1:0]  ONE_Q24     = ENV_W'(25'd16777216);
  localparam logic [GAIN_W-1:0] GAIN_RESET  = 16'd4096;
  localparam logic [SINE_W-1:0] SINE_MAX    = 16'd32767;
  localparam logic [63:0]       HALF_PI_Q30 = 64'd1686629713;

  // Taylor divisors (2n)(2n+1) for the sine series terms.
  localparam logic [63:0] TAYLOR_DIV [7] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210
  };

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_SAMPLE     = 3'd0,
    CFG_SAMPLE_COUNT     = 3'd1,
    CFG_PHASE_STEP_START = 3'd2,
    CFG_PHASE_STEP_SLOPE = 3'd3,
    CFG_DECAY_FACTOR     = 3'd4,
    CFG_TONE_GAIN        = 3'd5,
    CFG_HARMONIC_GAIN    = 3'd6
  } cfg_reg_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP,
    ST_SIN1,
    ST_SIN3,
    ST_HARM,
    ST_MIX,
    ST_TONE,
    ST_DONE
  } ctm_state_t;

  // Operation of the shared multiplier.
  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_GAIN_ENV,
    MUL_ENV_DECAY,
    MUL_HARM,
    MUL_TONE
  } mul_op_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    capture;
    logic    advance;
    logic    rd_s1;
    logic    rd_s3;
    logic    upd_env;
    logic    latch_mix;
    logic    out_load;
    mul_op_t mul_op;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_window;
    logic out_free;
  } dp_status_t;

endpackage

FILE: rtl/core/ctm_ctrl.sv
module ctm_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  ctm_pkg::dp_status_t status,
  output ctm_pkg::dp_cmd_t    cmd
);

  ctm_pkg::ctm_state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ctm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      ctm_pkg::ST_IDLE: begin
        if (in_valid) state_next = ctm_pkg::ST_STEP;
      end
      ctm_pkg::ST_STEP: begin
        state_next = status.in_window ? ctm_pkg::ST_SIN1 : ctm_pkg::ST_DONE;
      end
      ctm_pkg::ST_SIN1: state_next = ctm_pkg::ST_SIN3;
      ctm_pkg::ST_SIN3: state_next = ctm_pkg::ST_HARM;
      ctm_pkg::ST_HARM: state_next = ctm_pkg::ST_MIX;
      ctm_pkg::ST_MIX:  state_next = ctm_pkg::ST_TONE;
      ctm_pkg::ST_TONE: state_next = ctm_pkg::ST_DONE;
      ctm_pkg::ST_DONE: begin
        if (status.out_free) state_next = ctm_pkg::ST_IDLE;
      end
    endcase
  end

  // Output decode: at most one multiplier operation and at most one ROM read per state.
  always_comb begin
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.mul_op = ctm_pkg::MUL_NONE;
    unique case (state)
      ctm_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ctm_pkg::ST_STEP: cmd.advance = 1'b1;
      ctm_pkg::ST_SIN1: begin
        cmd.rd_s1  = 1'b1;
        cmd.mul_op = ctm_pkg::MUL_GAIN_ENV;
      end
      ctm_pkg::ST_SIN3: begin
        cmd.rd_s3  = 1'b1;
        cmd.mul_op = ctm_pkg::MUL_ENV_DECAY;
      end
      ctm_pkg::ST_HARM: begin
        cmd.upd_env = 1'b1;
        cmd.mul_op  = ctm_pkg::MUL_HARM;
      end
      ctm_pkg::ST_MIX:  cmd.latch_mix = 1'b1;
      ctm_pkg::ST_TONE: cmd.mul_op = ctm_pkg::MUL_TONE;
      ctm_pkg::ST_DONE: cmd.out_load = status.out_free;
    endcase
  end

endmodule

FILE: rtl/core/ctm_datapath.sv
module ctm_datapath #(
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [ctm_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [ctm_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic signed [ctm_pkg::MIX_W-1:0]     mix_in,
  input  logic                                 restart,
  input  ctm_pkg::dp_cmd_t                     cmd,
  output ctm_pkg::dp_status_t                  status,
  input  logic                                 out_ready,
  output logic                                 out_valid,
  output logic signed [ctm_pkg::MIX_W-1:0]     mix_out,
  output logic                                 tone_active
);

  localparam int ADDR_W = $clog2(SINE_TABLE_DEPTH);
  localparam int IDX_W  = $clog2(4 * SINE_TABLE_DEPTH);
  localparam int IPROD_W = ctm_pkg::PHASE_W + IDX_W;
  localparam logic [IPROD_W-1:0] IDX_SCALE = IPROD_W'(4 * SINE_TABLE_DEPTH);
  localparam logic [IDX_W-1:0]   QD1 = IDX_W'(SINE_TABLE_DEPTH);
  localparam logic [IDX_W-1:0]   QD2 = IDX_W'(2 * SINE_TABLE_DEPTH);
  localparam logic [IDX_W-1:0]   QD3 = IDX_W'(3 * SINE_TABLE_DEPTH);
  // Wraps to zero for a power-of-two depth, which still gives depth minus offset.
  localparam logic [ADDR_W-1:0]  DEPTH_A = ADDR_W'(SINE_TABLE_DEPTH);
  localparam logic signed [ctm_pkg::PROD_W-1:0] ROUND_HALF =
    ctm_pkg::PROD_W'(64'd1 << (ctm_pkg::FRAC_SHIFT - 1));

  typedef logic [ctm_pkg::SINE_W-1:0] sine_rom_t [SINE_TABLE_DEPTH];

  // Quarter-wave sine, Q1.15, built at elaboration from a Q30 Taylor series.
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t   rom;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
      x  = (ctm_pkg::HALF_PI_Q30 * 64'(k)) / SINE_TABLE_DEPTH;
      x2 = (x * x) >> 30;
      t  = x;
      s  = x;
      for (int n = 1; n <= 7; n++) begin
        t = ((t * x2) >> 30) / ctm_pkg::TAYLOR_DIV[n-1];
        if ((n & 1) == 1) s = s - t;
        else              s = s + t;
      end
      s = (s + 64'd16384) >> 15;
      rom[k] = (s > 64'd32767) ? ctm_pkg::SINE_MAX : s[ctm_pkg::SINE_W-1:0];
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

  // Configuration registers.
  logic [ctm_pkg::POS_W-1:0]          start_sample;
  logic [ctm_pkg::POS_W-1:0]          sample_count;
  logic [ctm_pkg::PHASE_W-1:0]        phase_step_start;
  logic [ctm_pkg::PHASE_W-1:0]        phase_step_slope;
  logic [ctm_pkg::ENV_W-1:0]          decay_factor;
  logic signed [ctm_pkg::GAIN_W-1:0]  tone_gain;
  logic signed [ctm_pkg::GAIN_W-1:0]  harmonic_gain;

  // Oscillator state.
  logic [ctm_pkg::POS_W-1:0]          buffer_position;
  logic [ctm_pkg::PHASE_W-1:0]        phase_acc;
  logic [ctm_pkg::PHASE_W-1:0]        step_acc;
  logic [ctm_pkg::ENV_W-1:0]          envelope;

  // Per-item working registers.
  logic signed [ctm_pkg::MIX_W-1:0]    mix_in_q;
  logic                                restart_q;
  logic                                active_q;
  logic [ctm_pkg::PHASE_W-1:0]         phase3;
  logic [ctm_pkg::SINE_W-1:0]          rom_q;
  logic                                neg_q;
  logic                                max_q;
  logic signed [ctm_pkg::SINE_W-1:0]   s1_q;
  logic signed [ctm_pkg::GE_W-1:0]     ge_q;
  logic signed [ctm_pkg::MIXSUM_W-1:0] mix_q;
  logic signed [ctm_pkg::PROD_W-1:0]   prod;

  // Configuration writes; an index past the list is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      start_sample     <= '0;
      sample_count     <= '0;
      phase_step_start <= '0;
      phase_step_slope <= '0;
      decay_factor     <= ctm_pkg::ONE_Q24;
      tone_gain        <= ctm_pkg::GAIN_RESET;
      harmonic_gain    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ctm_pkg::CFG_START_SAMPLE:     start_sample     <= cfg_data[ctm_pkg::POS_W-1:0];
        ctm_pkg::CFG_SAMPLE_COUNT:     sample_count     <= cfg_data[ctm_pkg::POS_W-1:0];
        ctm_pkg::CFG_PHASE_STEP_START: phase_step_start <= cfg_data[ctm_pkg::PHASE_W-1:0];
        ctm_pkg::CFG_PHASE_STEP_SLOPE: phase_step_slope <= cfg_data[ctm_pkg::PHASE_W-1:0];
        ctm_pkg::CFG_DECAY_FACTOR:     decay_factor     <= cfg_data[ctm_pkg::ENV_W-1:0];
        ctm_pkg::CFG_TONE_GAIN:        tone_gain        <= cfg_data[ctm_pkg::GAIN_W-1:0];
        ctm_pkg::CFG_HARMONIC_GAIN:    harmonic_gain    <= cfg_data[ctm_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Input capture.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mix_in_q  <= mix_in;
      restart_q <= restart;
    end
  end

  // Window test and the values the oscillator restarts from.
  logic [ctm_pkg::POS_W-1:0]   pos_eff;
  logic [ctm_pkg::POS_W-1:0]   pos_delta;
  logic                        in_window;
  logic                        reload;
  logic [ctm_pkg::PHASE_W-1:0] base_phase;
  logic [ctm_pkg::PHASE_W-1:0] base_step;
  logic [ctm_pkg::ENV_W-1:0]   base_env;

  always_comb begin
    pos_eff    = restart_q ? '0 : buffer_position;
    pos_delta  = pos_eff - start_sample;
    in_window  = (pos_eff >= start_sample) && (pos_delta < sample_count);
    reload     = restart_q || (in_window && (pos_eff == start_sample));
    base_phase = reload ? '0 : phase_acc;
    base_step  = reload ? phase_step_start : step_acc;
    base_env   = reload ? ctm_pkg::ONE_Q24 : envelope;
  end

  assign status.in_window = in_window;

  // Rounding of the shared product by 2^-24, half up.
  logic signed [ctm_pkg::PROD_W-1:0] prod_rnd;
  logic [ctm_pkg::ENV_W:0]           env_rnd;
  logic signed [ctm_pkg::TONE_W-1:0] tone;

  always_comb begin
    prod_rnd = prod + ROUND_HALF;
    env_rnd  = prod_rnd[ctm_pkg::FRAC_SHIFT +: (ctm_pkg::ENV_W + 1)];
    tone     = prod_rnd[ctm_pkg::FRAC_SHIFT +: ctm_pkg::TONE_W];
  end

  // Oscillator state update: position advances, phase and step advance inside the window, envelope decays.
  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_position <= '0;
      phase_acc       <= '0;
      step_acc        <= '0;
      envelope        <= ctm_pkg::ONE_Q24;
      active_q        <= 1'b0;
    end else if (cmd.advance) begin
      buffer_position <= pos_eff + ctm_pkg::POS_W'(1);
      envelope        <= base_env;
      active_q        <= in_window;
      if (in_window) begin
        phase_acc <= base_phase + base_step;
        step_acc  <= base_step + phase_step_slope;
      end else begin
        phase_acc <= base_phase;
        step_acc  <= base_step;
      end
    end else if (cmd.upd_env) begin
      envelope <= env_rnd[ctm_pkg::ENV_W] ? '1 : env_rnd[ctm_pkg::ENV_W-1:0];
    end
  end

  // Triple phase for the third harmonic.
  always_ff @(posedge clk) begin
    if (cmd.rd_s1) phase3 <= phase_acc + {phase_acc[ctm_pkg::PHASE_W-2:0], 1'b0};
  end

  // Sine lookup: table index, quadrant and mirrored offset.
  logic [ctm_pkg::PHASE_W-1:0] rd_phase;
  logic [IPROD_W-1:0]          idx_prod;
  logic [IDX_W-1:0]            idx;
  logic [IDX_W-1:0]            rem;
  logic [1:0]                  quad;
  logic [ADDR_W-1:0]           offset;
  logic [ADDR_W-1:0]           rd_addr;
  logic                        rd_max;

  always_comb begin
    rd_phase = cmd.rd_s3 ? phase3 : phase_acc;
    idx_prod = {{IDX_W{1'b0}}, rd_phase} * IDX_SCALE;
    idx      = idx_prod[IPROD_W-1:ctm_pkg::PHASE_W];
    priority if (idx < QD1) begin
      quad = 2'd0;
      rem  = idx;
    end else if (idx < QD2) begin
      quad = 2'd1;
      rem  = idx - QD1;
    end else if (idx < QD3) begin
      quad = 2'd2;
      rem  = idx - QD2;
    end else begin
      quad = 2'd3;
      rem  = idx - QD3;
    end
    offset  = rem[ADDR_W-1:0];
    // Odd quadrants run the table backward; offset zero there is the peak.
    rd_max  = quad[0] && (offset == '0);
    rd_addr = quad[0] ? (DEPTH_A - offset) : offset;
  end

  // Sine ROM with registered read.
  always_ff @(posedge clk) begin
    if (cmd.rd_s1 || cmd.rd_s3) begin
      rom_q <= SINE_ROM[rd_addr];
      neg_q <= quad[1];
      max_q <= rd_max;
    end
  end

  logic signed [ctm_pkg::SINE_W-1:0] sine_mag;
  logic signed [ctm_pkg::SINE_W-1:0] sine_val;

  always_comb begin
    sine_mag = max_q ? ctm_pkg::SINE_MAX : rom_q;
    sine_val = neg_q ? -sine_mag : sine_mag;
  end

  // The first sine and the gain-envelope product are ready together.
  always_ff @(posedge clk) begin
    if (cmd.rd_s3) begin
      s1_q <= sine_val;
      ge_q <= prod_rnd[ctm_pkg::FRAC_SHIFT +: ctm_pkg::GE_W];
    end
  end

  // Fundamental plus weighted third harmonic, Q.27.
  always_ff @(posedge clk) begin
    if (cmd.latch_mix) begin
      mix_q <= (ctm_pkg::MIXSUM_W'(s1_q) <<< ctm_pkg::SINE_SHIFT)
             + $signed(prod[ctm_pkg::MIXSUM_W-1:0]);
    end
  end

  // Shared multiplier operand selection.
  logic signed [ctm_pkg::MUL_A_W-1:0] mul_a;
  logic signed [ctm_pkg::MUL_B_W-1:0] mul_b;

  always_comb begin
    unique case (cmd.mul_op)
      ctm_pkg::MUL_GAIN_ENV: begin
        mul_a = $signed({1'b0, envelope});
        mul_b = ctm_pkg::MUL_B_W'(tone_gain);
      end
      ctm_pkg::MUL_ENV_DECAY: begin
        mul_a = $signed({1'b0, envelope});
        mul_b = $signed({{(ctm_pkg::MUL_B_W - ctm_pkg::ENV_W){1'b0}}, decay_factor});
      end
      ctm_pkg::MUL_HARM: begin
        mul_a = ctm_pkg::MUL_A_W'(sine_val);
        mul_b = ctm_pkg::MUL_B_W'(harmonic_gain);
      end
      ctm_pkg::MUL_TONE: begin
        mul_a = ctm_pkg::MUL_A_W'(ge_q);
        mul_b = ctm_pkg::MUL_B_W'(mix_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_op != ctm_pkg::MUL_NONE) begin
      prod <= ctm_pkg::PROD_W'(mul_a) * ctm_pkg::PROD_W'(mul_b);
    end
  end

  // Mix the tone into the input and saturate to the sample range.
  logic signed [ctm_pkg::MIX_W+4:0]  sum;
  logic signed [ctm_pkg::MIX_W-1:0]  sum_sat;

  always_comb begin
    sum = (ctm_pkg::MIX_W + 5)'(mix_in_q) + (ctm_pkg::MIX_W + 5)'(tone);
    priority if (sum[ctm_pkg::MIX_W+4] && !(&sum[ctm_pkg::MIX_W+3:ctm_pkg::MIX_W-1])) begin
      sum_sat = {1'b1, {(ctm_pkg::MIX_W - 1){1'b0}}};
    end else if (!sum[ctm_pkg::MIX_W+4] && (|sum[ctm_pkg::MIX_W+3:ctm_pkg::MIX_W-1])) begin
      sum_sat = {1'b0, {(ctm_pkg::MIX_W - 1){1'b1}}};
    end else begin
      sum_sat = sum[ctm_pkg::MIX_W-1:0];
    end
  end

  // Output register; the input side is free once no result waits or the waiting one is taken.
  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      mix_out     <= active_q ? sum_sat : mix_in_q;
      tone_active <= active_q;
    end
  end

endmodule

FILE: rtl/core/chirp_tone_mixer_top.sv
// A sample inside the tone window passes the step, sine, harmonic, mix and tone
// states, one outside it only the step state; the shared multiplier runs four
// products in sequence. A new input beat is taken only after the previous result
// is loaded, one output register deep; a stalled result delays intake.
// Reset (rst, synchronous): registers return to their reset values, position,
// phase and step clear, the envelope returns to 1.0 and no result is pending.
module chirp_tone_mixer_top #(
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic                              clk,
  input  logic                              rst,
  // Input stream.
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [ctm_pkg::TDATA_W-1:0]       s_axis_tdata,   // [19:0] mix_in
  input  logic                              s_axis_tuser,   // [0] restart
  // Output stream.
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [ctm_pkg::TDATA_W-1:0]       m_axis_tdata,   // [19:0] mix_out
  output logic                              m_axis_tuser,   // [0] tone_active
  // Configuration write port.
  input  logic                              cfg_we,
  input  logic [ctm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ctm_pkg::CFG_DATA_W-1:0]    cfg_data
);

  ctm_pkg::dp_cmd_t    cmd;
  ctm_pkg::dp_status_t status;
  logic signed [ctm_pkg::MIX_W-1:0] mix_out;

  ctm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  ctm_datapath #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mix_in      ($signed(s_axis_tdata[ctm_pkg::MIX_W-1:0])),
    .restart     (s_axis_tuser),
    .cmd         (cmd),
    .status      (status),
    .out_ready   (m_axis_tready),
    .out_valid   (m_axis_tvalid),
    .mix_out     (mix_out),
    .tone_active (m_axis_tuser)
  );

  // Pad the sample up to whole bytes.
  assign m_axis_tdata = {{(ctm_pkg::TDATA_W - ctm_pkg::MIX_W){1'b0}}, mix_out};

endmodule

FILE: rtl/core/ctm_checker.sv
`include "assert_macros.svh"

module ctm_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        s_axis_tvalid,
  input logic                        s_axis_tready,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [ctm_pkg::TDATA_W-1:0] m_axis_tdata,
  input logic                        m_axis_tuser
);

  // A stalled result beat keeps its contents.
  `ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

  // One sample is worked at a time: intake closes right after a beat.
  `ASSERT_NEXT(a_one_at_a_time, clk, rst, s_axis_tvalid && s_axis_tready, !s_axis_tready)

  // A new result only appears as the block finishes a sample.
  `ASSERT_IMPLIES(a_result_from_work, clk, rst, $rose(m_axis_tvalid), !$past(s_axis_tready))

  // The byte padding above the sample stays zero.
  `ASSERT_IMPLIES(a_pad_zero, clk, rst, m_axis_tvalid, m_axis_tdata[ctm_pkg::TDATA_W-1:ctm_pkg::MIX_W] == '0)

endmodule

bind chirp_tone_mixer_top ctm_checker u_ctm_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
